@@ rtl/decimating_complex_fir_core_defines.svh @@
// Assertion helpers used by the filter core RTL.
`ifndef DECIMATING_COMPLEX_FIR_CORE_DEFINES_SVH
`define DECIMATING_COMPLEX_FIR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCFIR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCFIR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dcfir_pkg.sv @@
`timescale 1ns / 1ps

package dcfir_pkg;

	localparam int MAX_TAPS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS       = 16;
	localparam int TAP_COUNT_BITS  = 7;
	localparam int DECIM_BITS      = 8;
	localparam int TAP_INDEX_BITS  = 6;
	localparam int CMD_BITS        = 2;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int CFG_DATA_BITS   = 8;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_SAMPLE    = 2'd0,
		CMD_TAP_WRITE = 2'd1,
		CMD_CLEAR     = 2'd2
	} cmd_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TAP_COUNT = 1'b0,
		REG_DECIM     = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic shift;
		logic rotate;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
		logic use_tap;
	} mac_ctl_t;

endpackage

@@ rtl/dcfir_cell.sv @@
`timescale 1ns / 1ps

module dcfir_cell #(
	parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  dcfir_pkg::cell_ctl_t                     ctl,
	input  logic                                     tap_we,
	input  logic signed [dcfir_pkg::COEF_BITS-1:0]   tap_value,
	input  logic signed [SAMPLE_BITS-1:0]            left_re,
	input  logic signed [SAMPLE_BITS-1:0]            left_im,
	input  logic signed [SAMPLE_BITS-1:0]            right_re,
	input  logic signed [SAMPLE_BITS-1:0]            right_im,
	input  logic signed [dcfir_pkg::COEF_BITS-1:0]   right_h,
	output logic signed [SAMPLE_BITS-1:0]            x_re,
	output logic signed [SAMPLE_BITS-1:0]            x_im,
	output logic signed [dcfir_pkg::COEF_BITS-1:0]   h
);
	import dcfir_pkg::*;

	logic signed [SAMPLE_BITS-1:0] x_re_q;
	logic signed [SAMPLE_BITS-1:0] x_im_q;
	logic signed [COEF_BITS-1:0]   h_q;

	// history: clears on a clear, shifts on a new sample, rotates with the tap during a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_re_q <= '0;
			x_im_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				x_re_q <= '0;
				x_im_q <= '0;
			end else if (ctl.shift) begin
				x_re_q <= left_re;
				x_im_q <= left_im;
			end else if (ctl.rotate) begin
				x_re_q <= right_re;
				x_im_q <= right_im;
			end else begin
				x_re_q <= x_re_q;
				x_im_q <= x_im_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.rotate) begin
			h_q <= right_h;
		end else if (tap_we) begin
			h_q <= tap_value;
		end else begin
			h_q <= h_q;
		end
	end

	assign x_re = x_re_q;
	assign x_im = x_im_q;
	assign h    = h_q;

endmodule

@@ rtl/dcfir_mac.sv @@
`timescale 1ns / 1ps

module dcfir_mac #(
	parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_TAPS    = dcfir_pkg::MAX_TAPS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  dcfir_pkg::mac_ctl_t                      ctl,
	input  logic signed [SAMPLE_BITS-1:0]            x_re,
	input  logic signed [SAMPLE_BITS-1:0]            x_im,
	input  logic signed [dcfir_pkg::COEF_BITS-1:0]   h,
	output logic signed [SAMPLE_BITS+dcfir_pkg::COEF_BITS+$clog2(MAX_TAPS)-1:0] acc_re,
	output logic signed [SAMPLE_BITS+dcfir_pkg::COEF_BITS+$clog2(MAX_TAPS)-1:0] acc_im,
	output logic                                     done
);
	import dcfir_pkg::*;

	localparam int ProdBits = SAMPLE_BITS + COEF_BITS;
	localparam int AccBits  = ProdBits + $clog2(MAX_TAPS);

	logic signed [ProdBits-1:0] prod_re_s1;
	logic signed [ProdBits-1:0] prod_im_s1;
	mac_ctl_t                   ctl_s1;
	logic signed [AccBits-1:0]  acc_re_q;
	logic signed [AccBits-1:0]  acc_im_q;
	logic signed [AccBits-1:0]  base_re;
	logic signed [AccBits-1:0]  base_im;
	logic signed [AccBits-1:0]  add_re;
	logic signed [AccBits-1:0]  add_im;
	logic                       done_q;

	always_ff @(posedge clk) begin
		prod_re_s1 <= h * x_re;
		prod_im_s1 <= h * x_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			done_q <= ctl_s1.vld && ctl_s1.last;
		end
	end

	// taps past the configured count add nothing
	always_comb begin
		base_re = ctl_s1.first ? '0 : acc_re_q;
		base_im = ctl_s1.first ? '0 : acc_im_q;
		add_re  = ctl_s1.use_tap ? AccBits'(prod_re_s1) : '0;
		add_im  = ctl_s1.use_tap ? AccBits'(prod_im_s1) : '0;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			acc_re_q <= base_re + add_re;
			acc_im_q <= base_im + add_im;
		end
	end

	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;
	assign done   = done_q;

endmodule

@@ rtl/decimating_complex_fir_core.sv @@
`timescale 1ns / 1ps
`include "decimating_complex_fir_core_defines.svh"

// Decimating FIR on complex samples with real Q1.15 taps. History and taps
// live in a ring of MAX_TAPS cells; cell k holds x[n-k] and h[k]. Tap
// writes, clears and samples that do not land on phase zero cause no stall.
// A sample on phase zero rotates the ring once around past a single
// shared multiply-accumulate pair, so the block stalls its input from
// accepting it until the full-precision sums are loaded into the output
// register, also waiting there while an older result is held; the block
// then takes further items while that result waits.
module decimating_complex_fir_core #(
	parameter int MAX_TAPS    = dcfir_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [dcfir_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
	input  logic [dcfir_pkg::CFG_DATA_BITS-1:0]           cfg_data,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic [dcfir_pkg::CMD_BITS-1:0]                cmd,
	input  logic signed [SAMPLE_BITS-1:0]                 sample_re,
	input  logic signed [SAMPLE_BITS-1:0]                 sample_im,
	input  logic [dcfir_pkg::TAP_INDEX_BITS-1:0]          tap_index,
	input  logic signed [dcfir_pkg::COEF_BITS-1:0]        tap_value,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output logic signed [SAMPLE_BITS+dcfir_pkg::COEF_BITS+$clog2(MAX_TAPS)-1:0] out_re,
	output logic signed [SAMPLE_BITS+dcfir_pkg::COEF_BITS+$clog2(MAX_TAPS)-1:0] out_im
);
	import dcfir_pkg::*;

	localparam int AccBits  = SAMPLE_BITS + COEF_BITS + $clog2(MAX_TAPS);
	localparam int StepBits = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CntBits  = $clog2(MAX_TAPS + 1);

	// configuration
	logic [TAP_COUNT_BITS-1:0] tap_count_q;
	logic [DECIM_BITS-1:0]     decim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_BITS'(1);
			decim_q     <= DECIM_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAP_COUNT: tap_count_q <= cfg_data[TAP_COUNT_BITS-1:0];
				REG_DECIM:     decim_q     <= cfg_data[DECIM_BITS-1:0];
				default:       ;
			endcase
		end
	end

	logic [CntBits-1:0]    taps_eff;
	logic [DECIM_BITS-1:0] decim_eff;

	always_comb begin
		priority if (tap_count_q == '0) begin
			taps_eff = CntBits'(1);
		end else if (32'(tap_count_q) > MAX_TAPS) begin
			taps_eff = CntBits'(MAX_TAPS);
		end else begin
			taps_eff = CntBits'(tap_count_q);
		end
		decim_eff = (decim_q == '0) ? DECIM_BITS'(1) : decim_q;
	end

	// control
	state_t              state_q;
	state_t              state_d;
	logic [StepBits-1:0] step_q;
	logic [DECIM_BITS-1:0] phase_q;
	logic [DECIM_BITS:0] phase_inc;
	logic                accept;
	logic                start;
	logic                issue;
	logic                step_last;
	logic                out_free;
	logic                load;
	logic                mac_done;
	logic                tap_wr;
	cell_ctl_t           cell_ctl;
	mac_ctl_t            mac_ctl;
	logic                out_valid_q;

	assign accept    = in_valid && !in_stall;
	assign tap_wr    = accept && (cmd == CMD_TAP_WRITE);
	assign start     = cell_ctl.shift && (phase_q == '0);
	assign step_last = (step_q == StepBits'(MAX_TAPS - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign phase_inc = {1'b0, phase_q} + (DECIM_BITS + 1)'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_RUN;
			S_RUN:   if (step_last) state_d = S_DRAIN;
			S_DRAIN: begin
				if (mac_done) state_d = out_free ? S_IDLE : S_HOLD;
			end
			S_HOLD:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			S_IDLE:  in_stall = 1'b0;
			S_RUN:   issue = 1'b1;
			S_DRAIN: load = mac_done && out_free;
			S_HOLD:  load = out_free;
			default: ;
		endcase
	end

	always_comb begin
		cell_ctl.shift   = accept && (cmd == CMD_SAMPLE);
		cell_ctl.clear   = accept && (cmd == CMD_CLEAR);
		cell_ctl.rotate  = issue;
		mac_ctl.vld      = issue;
		mac_ctl.first    = (step_q == '0);
		mac_ctl.last     = step_last;
		mac_ctl.use_tap  = (CntBits'(step_q) < taps_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				step_q <= '0;
			end else if (issue) begin
				step_q <= step_q + StepBits'(1);
			end
			if (cell_ctl.clear) begin
				phase_q <= '0;
			end else if (cell_ctl.shift) begin
				// wrap also when the factor was lowered below the phase
				phase_q <= (phase_inc >= {1'b0, decim_eff}) ? '0 : phase_inc[DECIM_BITS-1:0];
			end
		end
	end

	// ring of cells: cell 0 takes the new sample, the ring closes for rotation
	logic signed [SAMPLE_BITS-1:0] x_re_w [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] x_im_w [MAX_TAPS];
	logic signed [COEF_BITS-1:0]   h_w    [MAX_TAPS];
	logic                          tap_we_w [MAX_TAPS];

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] left_re;
		logic signed [SAMPLE_BITS-1:0] left_im;

		if (k == 0) begin : g_head
			assign left_re = sample_re;
			assign left_im = sample_im;
		end else begin : g_body
			assign left_re = x_re_w[k-1];
			assign left_im = x_im_w[k-1];
		end

		assign tap_we_w[k] = tap_wr && (32'(tap_index) == k);

		dcfir_cell #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.tap_we    (tap_we_w[k]),
			.tap_value (tap_value),
			.left_re   (left_re),
			.left_im   (left_im),
			.right_re  (x_re_w[(k+1) % MAX_TAPS]),
			.right_im  (x_im_w[(k+1) % MAX_TAPS]),
			.right_h   (h_w[(k+1) % MAX_TAPS]),
			.x_re      (x_re_w[k]),
			.x_im      (x_im_w[k]),
			.h         (h_w[k])
		);
	end

	logic signed [AccBits-1:0] acc_re;
	logic signed [AccBits-1:0] acc_im;

	dcfir_mac #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_TAPS    (MAX_TAPS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x_re   (x_re_w[0]),
		.x_im   (x_im_w[0]),
		.h      (h_w[0]),
		.acc_re (acc_re),
		.acc_im (acc_im),
		.done   (mac_done)
	);

	// output register
	logic signed [AccBits-1:0] out_re_q;
	logic signed [AccBits-1:0] out_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_re_q <= acc_re;
			out_im_q <= acc_im;
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;

	`DCFIR_ASSERT_NEXT(a_start_runs, clk, arst_n, start, state_q == S_RUN && step_q == '0, "pass did not start at step zero")
	`DCFIR_ASSERT_NOW(a_done_in_drain, clk, arst_n, mac_done, state_q == S_DRAIN, "accumulator finished outside drain")
	`DCFIR_ASSERT_NOW(a_rotate_alone, clk, arst_n, cell_ctl.rotate, !cell_ctl.shift && !cell_ctl.clear && !tap_wr, "ring disturbed during a pass")

endmodule
